// ===== design/register_bit_flip_tally_defines.svh =====
// Assertion macros shared by the bit flip tally checkers.
`ifndef REGISTER_BIT_FLIP_TALLY_DEFINES_SVH
`define REGISTER_BIT_FLIP_TALLY_DEFINES_SVH

// Condition that must hold in the same cycle as its trigger.
`define RBFT_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define RBFT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/rbft_pkg.sv =====
// Types and constants shared by the bit flip tally modules.
package rbft_pkg;

    // Fixed field widths
    localparam int DATA_BITS  = 8;
    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int SEL_W      = 6;
    localparam int CNT_BITS   = 4;
    localparam int INC_W      = 5;
    localparam int RD_W       = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    // Queue depths between the parts
    localparam int WORK_DEPTH = 2;
    localparam int RSP_DEPTH  = 2;

    // Configuration reset values
    localparam logic [COL_W-1:0] SYN_LIN_RESET  = 9'd128;
    localparam logic [COL_W-1:0] LIN_DIFF_RESET = 9'd264;
    localparam logic [ROW_W-1:0] ROW_SPLIT_RESET = 8'd96;

    // Bit positions of class 0 when column plus row is even
    localparam logic [DATA_BITS-1:0] EVEN_BITS = 8'h55;
    localparam logic [DATA_BITS-1:0] ODD_BITS  = 8'hAA;

    // Total tallies, offset from the first total
    localparam int NUM_TOTALS = 16;
    localparam logic [3:0] TOT_ALL       = 4'd0;
    localparam logic [3:0] TOT_SYN       = 4'd1;
    localparam logic [3:0] TOT_LIN       = 4'd2;
    localparam logic [3:0] TOT_DIFF      = 4'd3;
    localparam logic [3:0] TOT_UPPER     = 4'd4;
    localparam logic [3:0] TOT_LOWER     = 4'd5;
    localparam logic [3:0] TOT_SYN_UP    = 4'd6;
    localparam logic [3:0] TOT_SYN_LO    = 4'd7;
    localparam logic [3:0] TOT_LIN_UP    = 4'd8;
    localparam logic [3:0] TOT_LIN_LO    = 4'd9;
    localparam logic [3:0] TOT_DIFF_UP   = 4'd10;
    localparam logic [3:0] TOT_DIFF_LO   = 4'd11;
    localparam logic [3:0] TOT_CLS0      = 4'd12;
    localparam logic [3:0] TOT_CLS1      = 4'd13;
    localparam logic [3:0] TOT_REF_ONES  = 4'd14;
    localparam logic [3:0] TOT_REF_ZEROS = 4'd15;

    typedef enum logic [1:0] {
        ACT_COMPARE = 2'd0,
        ACT_READ    = 2'd1,
        ACT_CLEAR   = 2'd2
    } action_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYN_LIN   = 2'd0,
        CFG_LIN_DIFF  = 2'd1,
        CFG_ROW_SPLIT = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REG_SYN  = 2'd0,
        REG_LIN  = 2'd1,
        REG_DIFF = 2'd2
    } region_t;

    typedef struct packed {
        logic [1:0]           action;
        logic [COL_W-1:0]     column;
        logic [ROW_W-1:0]     pixel_row;
        logic [DATA_BITS-1:0] reference_value;
        logic [DATA_BITS-1:0] readback_value;
        logic [SEL_W-1:0]     counter_index;
    } req_t;

    typedef struct packed {
        logic [DATA_BITS-1:0] flip_mask;
        logic [CNT_BITS-1:0]  flip_count;
        logic [RD_W-1:0]      counter_value;
    } rsp_t;

    // Classified request passed from the front part to the back part
    typedef struct packed {
        logic                 do_cmp;
        logic                 do_read;
        logic                 do_clear;
        logic [DATA_BITS-1:0] mask;
        logic [DATA_BITS-1:0] cls0_mask;
        logic [CNT_BITS-1:0]  flips;
        logic [CNT_BITS-1:0]  cls0;
        logic [CNT_BITS-1:0]  cls1;
        logic [CNT_BITS-1:0]  ones;
        region_t              region;
        logic                 lower;
        logic [SEL_W-1:0]     sel;
    } work_t;

endpackage

// ===== design/rbft_fifo.sv =====
// Small register queue used between the front part, the back part and the result port.
module rbft_fifo #(
    parameter type entry_t = logic,
    parameter int  DEPTH   = 2
) (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push_en,
    input  entry_t wr_data,
    input  logic   pop_en,
    output entry_t rd_data,
    output logic   full,
    output logic   empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    entry_t           mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_COUNT);
    assign empty   = (count_reg == '0);
    assign do_push = push_en && !full;
    assign do_pop  = pop_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== design/rbft_front.sv =====
// Front part: configuration registers and classification of each request.
module rbft_front #(
    parameter int COLUMNS   = 400,
    parameter int ROWS      = 192,
    parameter int WORD_BITS = 8
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [rbft_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rbft_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  rbft_pkg::req_t                     req,
    output rbft_pkg::work_t                    work
);
    import rbft_pkg::*;

    localparam int LIM_W = 11;
    localparam logic [LIM_W-1:0] COL_LIM = LIM_W'(COLUMNS);
    localparam logic [LIM_W-1:0] ROW_LIM = LIM_W'(ROWS);
    localparam logic [DATA_BITS-1:0] WORD_KEEP =
        (WORD_BITS >= DATA_BITS) ? '1 : DATA_BITS'((1 << WORD_BITS) - 1);

    logic [COL_W-1:0] syn_lin_reg;
    logic [COL_W-1:0] lin_diff_reg;
    logic [ROW_W-1:0] row_split_reg;

    logic [DATA_BITS-1:0] ref_w, rb_w, mask, cls0_mask;
    logic [CNT_BITS-1:0]  flips, ones, cls0;
    logic                 on_array, parity;
    region_t              region;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            syn_lin_reg   <= SYN_LIN_RESET;
            lin_diff_reg  <= LIN_DIFF_RESET;
            row_split_reg <= ROW_SPLIT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_SYN_LIN:   syn_lin_reg   <= cfg_data;
                CFG_LIN_DIFF:  lin_diff_reg  <= cfg_data;
                CFG_ROW_SPLIT: row_split_reg <= cfg_data[ROW_W-1:0];
                default:       ;
            endcase
        end
    end

    // Compare the words and sort the flips into checkerboard classes
    assign ref_w     = req.reference_value & WORD_KEEP;
    assign rb_w      = req.readback_value & WORD_KEEP;
    assign mask      = ref_w ^ rb_w;
    assign parity    = req.column[0] ^ req.pixel_row[0];
    assign cls0_mask = mask & (parity ? ODD_BITS : EVEN_BITS);

    always_comb
    begin
        flips = '0;
        ones  = '0;
        cls0  = '0;
        for (int b = 0; b < DATA_BITS; b++)
        begin
            flips = flips + CNT_BITS'(mask[b]);
            ones  = ones + CNT_BITS'(ref_w[b]);
            cls0  = cls0 + CNT_BITS'(cls0_mask[b]);
        end
    end

    // Place the pixel in a region and a half
    assign on_array = ({2'b00, req.column} < COL_LIM) && ({3'b000, req.pixel_row} < ROW_LIM);

    always_comb
    begin
        if (req.column < syn_lin_reg)
        begin
            region = REG_SYN;
        end
        else if (req.column < lin_diff_reg)
        begin
            region = REG_LIN;
        end
        else
        begin
            region = REG_DIFF;
        end
    end

    // Build the queue entry
    always_comb
    begin
        work.do_cmp    = (req.action == ACT_COMPARE) && on_array;
        work.do_read   = (req.action == ACT_READ);
        work.do_clear  = (req.action == ACT_CLEAR);
        work.mask      = mask;
        work.cls0_mask = cls0_mask;
        work.flips     = flips;
        work.cls0      = cls0;
        work.cls1      = flips - cls0;
        work.ones      = ones;
        work.region    = region;
        work.lower     = !(req.pixel_row < row_split_reg);
        work.sel       = req.counter_index;
    end

endmodule

// ===== design/rbft_back.sv =====
// Back part: saturating tallies, clear and counter read for each queued request.
module rbft_back #(
    parameter int WORD_BITS     = 8,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  rbft_pkg::work_t work,
    input  logic            work_valid,
    output logic            work_take,
    output rbft_pkg::rsp_t  rsp,
    output logic            rsp_push,
    input  logic            rsp_full
);
    import rbft_pkg::*;

    localparam int CW    = COUNTER_WIDTH;
    localparam int IDX_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int S_W   = SEL_W + 1;
    localparam logic [S_W-1:0] LIM_BIT  = S_W'(WORD_BITS);
    localparam logic [S_W-1:0] LIM_CLS0 = S_W'(2 * WORD_BITS);
    localparam logic [S_W-1:0] LIM_CLS1 = S_W'(3 * WORD_BITS);
    localparam logic [S_W-1:0] LIM_TOT  = S_W'(3 * WORD_BITS + NUM_TOTALS);

    logic [CW-1:0] bit_cnt_reg  [WORD_BITS];
    logic [CW-1:0] bit_cnt_next [WORD_BITS];
    logic [CW-1:0] c0_cnt_reg   [WORD_BITS];
    logic [CW-1:0] c0_cnt_next  [WORD_BITS];
    logic [CW-1:0] c1_cnt_reg   [WORD_BITS];
    logic [CW-1:0] c1_cnt_next  [WORD_BITS];
    logic [CW-1:0] tot_cnt_reg  [NUM_TOTALS];
    logic [CW-1:0] tot_cnt_next [NUM_TOTALS];

    logic [INC_W-1:0]     tot_inc [NUM_TOTALS];
    logic [WORD_BITS-1:0] mask_w, cls0_w;
    logic [INC_W-1:0]     flips5;
    logic [S_W-1:0]       sel_w, off_cls0, off_cls1, off_tot;
    logic [CW-1:0]        rd_val;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] v,
                                              input logic [INC_W-1:0] n);
        logic [CW:0] s;
        begin
            s = {1'b0, v} + (CW + 1)'(n);
            return s[CW] ? '1 : s[CW-1:0];
        end
    endfunction

    assign work_take = work_valid && !rsp_full;
    assign rsp_push  = work_take;
    assign mask_w    = WORD_BITS'(work.mask);
    assign cls0_w    = WORD_BITS'(work.cls0_mask);
    assign flips5    = INC_W'(work.flips);

    // Route flips into the total tallies
    always_comb
    begin
        for (int k = 0; k < NUM_TOTALS; k++)
        begin
            tot_inc[k] = '0;
        end
        tot_inc[TOT_ALL]   = flips5;
        tot_inc[TOT_SYN]   = (work.region == REG_SYN) ? flips5 : '0;
        tot_inc[TOT_LIN]   = (work.region == REG_LIN) ? flips5 : '0;
        tot_inc[TOT_DIFF]  = (work.region == REG_DIFF) ? flips5 : '0;
        tot_inc[TOT_UPPER] = !work.lower ? flips5 : '0;
        tot_inc[TOT_LOWER] = work.lower ? flips5 : '0;
        tot_inc[TOT_SYN_UP]  = (work.region == REG_SYN && !work.lower) ? flips5 : '0;
        tot_inc[TOT_SYN_LO]  = (work.region == REG_SYN && work.lower) ? flips5 : '0;
        tot_inc[TOT_LIN_UP]  = (work.region == REG_LIN && !work.lower) ? flips5 : '0;
        tot_inc[TOT_LIN_LO]  = (work.region == REG_LIN && work.lower) ? flips5 : '0;
        tot_inc[TOT_DIFF_UP] = (work.region == REG_DIFF && !work.lower) ? flips5 : '0;
        tot_inc[TOT_DIFF_LO] = (work.region == REG_DIFF && work.lower) ? flips5 : '0;
        tot_inc[TOT_CLS0]      = INC_W'(work.cls0);
        tot_inc[TOT_CLS1]      = INC_W'(work.cls1);
        tot_inc[TOT_REF_ONES]  = INC_W'(work.ones);
        tot_inc[TOT_REF_ZEROS] = INC_W'(WORD_BITS) - INC_W'(work.ones);
    end

    // Advance, clear or hold every tally
    always_comb
    begin
        bit_cnt_next = bit_cnt_reg;
        c0_cnt_next  = c0_cnt_reg;
        c1_cnt_next  = c1_cnt_reg;
        tot_cnt_next = tot_cnt_reg;
        if (work_take && work.do_clear)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                bit_cnt_next[i] = '0;
                c0_cnt_next[i]  = '0;
                c1_cnt_next[i]  = '0;
            end
            for (int k = 0; k < NUM_TOTALS; k++)
            begin
                tot_cnt_next[k] = '0;
            end
        end
        else if (work_take && work.do_cmp)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                bit_cnt_next[i] = sat_add(bit_cnt_reg[i], INC_W'(mask_w[i]));
                c0_cnt_next[i]  = sat_add(c0_cnt_reg[i], INC_W'(cls0_w[i]));
                c1_cnt_next[i]  = sat_add(c1_cnt_reg[i], INC_W'(mask_w[i] & ~cls0_w[i]));
            end
            for (int k = 0; k < NUM_TOTALS; k++)
            begin
                tot_cnt_next[k] = sat_add(tot_cnt_reg[k], tot_inc[k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                bit_cnt_reg[i] <= '0;
                c0_cnt_reg[i]  <= '0;
                c1_cnt_reg[i]  <= '0;
            end
            for (int k = 0; k < NUM_TOTALS; k++)
            begin
                tot_cnt_reg[k] <= '0;
            end
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            c0_cnt_reg  <= c0_cnt_next;
            c1_cnt_reg  <= c1_cnt_next;
            tot_cnt_reg <= tot_cnt_next;
        end
    end

    // Select the requested tally; an index past the last reads zero
    assign sel_w    = {1'b0, work.sel};
    assign off_cls0 = sel_w - LIM_BIT;
    assign off_cls1 = sel_w - LIM_CLS0;
    assign off_tot  = sel_w - LIM_CLS1;

    always_comb
    begin
        if (sel_w < LIM_BIT)
        begin
            rd_val = bit_cnt_reg[sel_w[IDX_W-1:0]];
        end
        else if (sel_w < LIM_CLS0)
        begin
            rd_val = c0_cnt_reg[off_cls0[IDX_W-1:0]];
        end
        else if (sel_w < LIM_CLS1)
        begin
            rd_val = c1_cnt_reg[off_cls1[IDX_W-1:0]];
        end
        else if (sel_w < LIM_TOT)
        begin
            rd_val = tot_cnt_reg[off_tot[3:0]];
        end
        else
        begin
            rd_val = '0;
        end
    end

    // Form the result; fields of other actions stay zero
    always_comb
    begin
        rsp.flip_mask     = work.do_cmp ? work.mask : '0;
        rsp.flip_count    = work.do_cmp ? work.flips : '0;
        rsp.counter_value = work.do_read ? RD_W'(rd_val) : '0;
    end

endmodule

// ===== design/register_bit_flip_tally.sv =====
// Bit flip tally top level: front classifier, work queue, tally back end, result queue.
// A request waits in the work queue until the result queue has room; its result then waits in the result queue.
// Throughput: one request per cycle unless full; the back end retires one queued request per cycle unless rsp_full.
// full rises only while the result queue is backed up by a stalled consumer.
// Reset: tallies clear to zero, boundaries return to 128, 264 and 96, both queues empty.
module register_bit_flip_tally #(
    parameter int COLUMNS       = 400,
    parameter int ROWS          = 192,
    parameter int WORD_BITS     = 8,
    parameter int COUNTER_WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  rbft_pkg::req_t                  req,
    output logic                            empty,
    input  logic                            pop,
    output rbft_pkg::rsp_t                  rsp,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rbft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rbft_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rbft_pkg::*;

    work_t work_in, work_out;
    logic  work_empty, work_take;
    rsp_t  rsp_in;
    logic  rsp_push, rsp_full;

    assign cfg_ready = 1'b1;

    // Classify each request and hold the configuration
    rbft_front #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .WORD_BITS (WORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req),
        .work      (work_in)
    );

    // Decouple the front from the tally back end
    rbft_fifo #(
        .entry_t (work_t),
        .DEPTH   (WORK_DEPTH)
    ) u_work_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (push),
        .wr_data (work_in),
        .pop_en  (work_take),
        .rd_data (work_out),
        .full    (full),
        .empty   (work_empty)
    );

    // Update tallies and build results
    rbft_back #(
        .WORD_BITS     (WORD_BITS),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (work_out),
        .work_valid (!work_empty),
        .work_take  (work_take),
        .rsp        (rsp_in),
        .rsp_push   (rsp_push),
        .rsp_full   (rsp_full)
    );

    // Hold results until popped
    rbft_fifo #(
        .entry_t (rsp_t),
        .DEPTH   (RSP_DEPTH)
    ) u_rsp_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_en (rsp_push),
        .wr_data (rsp_in),
        .pop_en  (pop),
        .rd_data (rsp),
        .full    (rsp_full),
        .empty   (empty)
    );

endmodule

// ===== design/rbft_checker.sv =====
// Port level checks for the bit flip tally, bound to the top level.
`include "register_bit_flip_tally_defines.svh"

module rbft_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           full,
    input logic           empty,
    input logic           pop,
    input rbft_pkg::rsp_t rsp
);
    import rbft_pkg::*;

    // Flip count always matches the mask it came with
    `RBFT_ASSERT_IMPL(a_count_matches_mask, !empty, $countones(rsp.flip_mask) == rsp.flip_count, "flip_count differs from flip_mask popcount")

    // A compare result never carries a counter value
    `RBFT_ASSERT_IMPL(a_one_kind, !empty && rsp.flip_count != 4'd0, rsp.counter_value == 32'd0, "compare result with nonzero counter_value")

    // Back pressure on requests only while results wait
    `RBFT_ASSERT_IMPL(a_full_backed_up, full, !empty, "full raised with no result waiting")

    // A waiting result holds until popped
    `RBFT_ASSERT_NEXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp), "waiting result changed before pop")

endmodule

bind register_bit_flip_tally rbft_checker u_rbft_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .full  (full),
    .empty (empty),
    .pop   (pop),
    .rsp   (rsp)
);
